FILE: hdl/vdcd_pkg.sv
package vdcd_pkg;

    // opcode field, bits 7:6 of a command byte
    typedef enum logic [1:0] {
        OPC_MOVE_X = 2'd0,
        OPC_MOVE_Y = 2'd1,
        OPC_PREFIX = 2'd2,
        OPC_CMD    = 2'd3
    } vdcd_opcode_t;

    // full command bytes under opcode 3
    localparam logic [7:0] CMD_PEN    = 8'hc0;
    localparam logic [7:0] CMD_PAUSE  = 8'hc1;
    localparam logic [7:0] CMD_CLEAR  = 8'hc2;
    localparam logic [7:0] CMD_KEY    = 8'hc3;
    localparam logic [7:0] CMD_COLOUR = 8'hc4;

    // result codes
    localparam logic [2:0] RES_LINE   = 3'd0;
    localparam logic [2:0] RES_PAUSE  = 3'd1;
    localparam logic [2:0] RES_CLEAR  = 3'd2;
    localparam logic [2:0] RES_KEY    = 3'd3;
    localparam logic [2:0] RES_COLOUR = 3'd4;

    localparam int OPERAND_W = 6;
    localparam int COORD_W   = 32;

    // one result beat plus its presence flag
    typedef struct packed {
        logic                      present;
        logic [2:0]                command;
        logic signed [COORD_W-1:0] from_x;
        logic signed [COORD_W-1:0] from_y;
        logic signed [COORD_W-1:0] to_x;
        logic signed [COORD_W-1:0] to_y;
        logic [COORD_W-1:0]        argument;
    } vdcd_result_t;

endpackage

FILE: hdl/vdcd_core.sv
module vdcd_core
    import vdcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   command_byte,
    output vdcd_result_t result
);

    logic [COORD_W-1:0] cur_x_reg, cur_x_next;
    logic [COORD_W-1:0] cur_y_reg, cur_y_next;
    logic [COORD_W-1:0] prev_x_reg, prev_x_next;
    logic [COORD_W-1:0] prev_y_reg, prev_y_next;
    logic               pen_down_reg, pen_down_next;
    logic               extending_reg, extending_next;
    logic [COORD_W-1:0] long_operand_reg, long_operand_next;
    logic [COORD_W-1:0] pause_delay_reg, pause_delay_next;

    vdcd_opcode_t         opc;
    logic [OPERAND_W-1:0] field;
    logic [COORD_W-1:0]   field_sext;
    logic [COORD_W-1:0]   field_shifted;
    logic [COORD_W-1:0]   amount;

    // operand forming
    assign opc           = vdcd_opcode_t'(command_byte[7:6]);
    assign field         = command_byte[OPERAND_W-1:0];
    assign field_sext    = {{(COORD_W-OPERAND_W){field[OPERAND_W-1]}}, field};
    assign field_shifted = {long_operand_reg[COORD_W-OPERAND_W-1:0], field};
    assign amount        = extending_reg ? field_shifted : field_sext;

    // next state and result for the byte in the input register
    always_comb
    begin
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        prev_x_next       = prev_x_reg;
        prev_y_next       = prev_y_reg;
        pen_down_next     = pen_down_reg;
        extending_next    = extending_reg;
        long_operand_next = long_operand_reg;
        pause_delay_next  = pause_delay_reg;
        result            = '0;

        unique case (opc)
            OPC_MOVE_X:
            begin
                cur_x_next        = cur_x_reg + amount;
                extending_next    = 1'b0;
                long_operand_next = '0;
            end
            OPC_MOVE_Y:
            begin
                cur_y_next        = cur_y_reg + amount;
                extending_next    = 1'b0;
                long_operand_next = '0;
                prev_x_next       = cur_x_reg;
                prev_y_next       = cur_y_next;
                if (pen_down_reg)
                begin
                    result.present = 1'b1;
                    result.command = RES_LINE;
                    result.from_x  = prev_x_reg;
                    result.from_y  = prev_y_reg;
                    result.to_x    = cur_x_reg;
                    result.to_y    = cur_y_next;
                end
            end
            OPC_PREFIX:
            begin
                long_operand_next = amount;
                extending_next    = 1'b1;
            end
            OPC_CMD:
            begin
                extending_next    = 1'b0;
                long_operand_next = '0;
                unique case (command_byte)
                    CMD_PEN:
                    begin
                        pen_down_next = ~pen_down_reg;
                    end
                    CMD_PAUSE:
                    begin
                        if (long_operand_reg != '0)
                        begin
                            pause_delay_next = long_operand_reg;
                        end
                        result.present  = 1'b1;
                        result.command  = RES_PAUSE;
                        result.argument = pause_delay_next;
                    end
                    CMD_CLEAR:
                    begin
                        result.present = 1'b1;
                        result.command = RES_CLEAR;
                    end
                    CMD_KEY:
                    begin
                        result.present = 1'b1;
                        result.command = RES_KEY;
                    end
                    CMD_COLOUR:
                    begin
                        result.present  = 1'b1;
                        result.command  = RES_COLOUR;
                        result.argument = long_operand_reg;
                    end
                    default:
                    begin
                        result.present = 1'b0;
                    end
                endcase
            end
            default:
            begin
                result.present = 1'b0;
            end
        endcase
    end

    // drawing state, committed when the byte leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            pen_down_reg     <= 1'b0;
            extending_reg    <= 1'b0;
            long_operand_reg <= '0;
            pause_delay_reg  <= '0;
        end
        else if (step)
        begin
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            prev_x_reg       <= prev_x_next;
            prev_y_reg       <= prev_y_next;
            pen_down_reg     <= pen_down_next;
            extending_reg    <= extending_next;
            long_operand_reg <= long_operand_next;
            pause_delay_reg  <= pause_delay_next;
        end
    end

endmodule

FILE: hdl/vector_draw_command_decoder_top.sv
// vector draw command decoder
// input channel: one command byte per beat on command_byte, handshake
// cmd_valid / cmd_ready. output channel: one draw result per beat on
// command, from_x, from_y, to_x, to_y and argument, handshake
// res_valid / res_ready. a byte yields zero or one result beat.
// a byte is captured in the input register, decoded against the
// drawing state, and its result lands in the output register, from
// which it is offered on the output channel.
// throughput: one byte per cycle unless a result waits on a stall, with
// the decode and 32-bit coordinate add combinational between the registers.
// when the receiver stalls, the held result stays on the outputs; bytes
// that yield no result still drain, and a byte that yields one waits in
// the input register, and cmd_ready is low while it waits.
// reset empties both pipeline registers and clears the current and
// previous point, the pen (up), the long operand and the pause delay.
module vector_draw_command_decoder_top
    import vdcd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  logic [7:0]                command_byte,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic [2:0]                command,
    output logic signed [COORD_W-1:0] from_x,
    output logic signed [COORD_W-1:0] from_y,
    output logic signed [COORD_W-1:0] to_x,
    output logic signed [COORD_W-1:0] to_y,
    output logic [COORD_W-1:0]        argument
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    vdcd_result_t out_reg;
    vdcd_result_t step_result;
    logic         out_free;
    logic         step;

    // input stage advances unless its result has nowhere to go
    assign out_free  = !out_valid_reg || res_ready;
    assign step      = in_valid_reg && (!step_result.present || out_free);
    assign cmd_ready = !in_valid_reg || step;

    vdcd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .command_byte (in_byte_reg),
        .result       (step_result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
        begin
            in_byte_reg <= command_byte;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step && step_result.present;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && step && step_result.present)
        begin
            out_reg <= step_result;
        end
    end

    assign res_valid = out_valid_reg;
    assign command   = out_reg.command;
    assign from_x    = out_reg.from_x;
    assign from_y    = out_reg.from_y;
    assign to_x      = out_reg.to_x;
    assign to_y      = out_reg.to_y;
    assign argument  = out_reg.argument;

endmodule

FILE: tb/vector_draw_command_decoder_top_test.sv
`timescale 1ns / 1ps

module vector_draw_command_decoder_top_test;
    import vdcd_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT_ITEM  = 400;
    localparam int FAST_ITEMS    = 150;
    localparam int DRAIN_CYCLES  = 16;
    localparam int REPORT_LIMIT  = 100;

    // how a stimulus row gets its expectation
    localparam int ROW_PREDICT = 0;
    localparam int ROW_BEAT    = 1;
    localparam int ROW_QUIET   = 2;

    // idle pacing styles
    localparam int PACE_NONE   = 0;
    localparam int PACE_ANY    = 1;
    localparam int PACE_SPARSE = 2;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] from_x;
        logic [31:0] from_y;
        logic [31:0] to_x;
        logic [31:0] to_y;
        logic [31:0] argument;
    } draw_beat_t;

    typedef struct {
        logic [7:0] code;
        int         kind;
        draw_beat_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_ready;
    logic [7:0]  command_byte;
    logic        res_valid;
    logic        res_ready;
    logic [2:0]  command;
    logic signed [COORD_W-1:0] from_x;
    logic signed [COORD_W-1:0] from_y;
    logic signed [COORD_W-1:0] to_x;
    logic signed [COORD_W-1:0] to_y;
    logic [COORD_W-1:0]        argument;

    // drawing state as the predictor sees it
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] last_x;
    logic [31:0] last_y;
    logic        pen_is_down;
    logic        in_prefix;
    logic [31:0] prefix_value;
    logic [31:0] held_delay;

    draw_beat_t  pending_beats[$];
    stim_row_t   stim_rows[$];
    draw_beat_t  got_want;

    int mismatches;
    int bytes_sent;
    int line_beats;
    int pause_beats;
    int other_beats;
    int input_stalls;
    int cycle_count;
    int tx_pace;
    int rx_pace;
    int fast_left;
    bit hold_request;

    vector_draw_command_decoder_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .command_byte (command_byte),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .command      (command),
        .from_x       (from_x),
        .from_y       (from_y),
        .to_x         (to_x),
        .to_y         (to_y),
        .argument     (argument)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // reset, asserted from time zero and then released
    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("vector_draw_command_decoder_top_test failed");
        $finish;
    end

    function automatic logic [7:0] make_byte(vdcd_opcode_t opc, logic [5:0] field);
        return {opc, field};
    endfunction

    function automatic draw_beat_t make_beat(logic [2:0] cmd, logic [31:0] fx,
                                             logic [31:0] fy, logic [31:0] tx,
                                             logic [31:0] ty, logic [31:0] arg);
        draw_beat_t beat;
        beat.command  = cmd;
        beat.from_x   = fx;
        beat.from_y   = fy;
        beat.to_x     = tx;
        beat.to_y     = ty;
        beat.argument = arg;
        return beat;
    endfunction

    function automatic logic [31:0] sign6(logic [5:0] field);
        return {{26{field[5]}}, field};
    endfunction

    function automatic int draw_wait(int pace);
        int cycles;
        cycles = 0;
        if (pace == PACE_ANY)
            cycles = $urandom_range(0, 15);
        else if (pace == PACE_SPARSE && $urandom_range(0, 7) == 0)
            cycles = $urandom_range(1, 15);
        return cycles;
    endfunction

    // move distance: short operand or the long one built by prefix bytes
    function logic [31:0] take_distance(logic [5:0] field);
        logic [31:0] distance;
        if (in_prefix)
            distance = {prefix_value[25:0], field};
        else
            distance = sign6(field);
        in_prefix    = 1'b0;
        prefix_value = '0;
        return distance;
    endfunction

    // advance the drawing state by one byte and say what it draws
    task predict_draw(input logic [7:0] code, output bit emits, output draw_beat_t beat);
        logic [5:0] field;
        field = code[5:0];
        emits = 1'b0;
        beat  = '0;
        case (vdcd_opcode_t'(code[7:6]))
            OPC_MOVE_X:
            begin
                pos_x = pos_x + take_distance(field);
            end
            OPC_MOVE_Y:
            begin
                pos_y = pos_y + take_distance(field);
                if (pen_is_down)
                begin
                    emits = 1'b1;
                    beat  = make_beat(RES_LINE, last_x, last_y, pos_x, pos_y, '0);
                end
                // previous point follows even with the pen up
                last_x = pos_x;
                last_y = pos_y;
            end
            OPC_PREFIX:
            begin
                if (in_prefix)
                    prefix_value = {prefix_value[25:0], field};
                else
                begin
                    prefix_value = sign6(field);
                    in_prefix    = 1'b1;
                end
            end
            default:
            begin
                case (code)
                    CMD_PEN:
                        pen_is_down = !pen_is_down;
                    CMD_PAUSE:
                    begin
                        // a zero long operand keeps the stored delay
                        if (prefix_value != '0)
                            held_delay = prefix_value;
                        emits = 1'b1;
                        beat  = make_beat(RES_PAUSE, '0, '0, '0, '0, held_delay);
                    end
                    CMD_CLEAR:
                    begin
                        emits = 1'b1;
                        beat  = make_beat(RES_CLEAR, '0, '0, '0, '0, '0);
                    end
                    CMD_KEY:
                    begin
                        emits = 1'b1;
                        beat  = make_beat(RES_KEY, '0, '0, '0, '0, '0);
                    end
                    CMD_COLOUR:
                    begin
                        emits = 1'b1;
                        beat  = make_beat(RES_COLOUR, '0, '0, '0, '0, prefix_value);
                    end
                    default:
                        ;
                endcase
                prefix_value = '0;
                in_prefix    = 1'b0;
            end
        endcase
    endtask

    task add_row(input logic [7:0] code, input int kind, input draw_beat_t want);
        stim_row_t row;
        row.code = code;
        row.kind = kind;
        row.want = want;
        stim_rows.push_back(row);
    endtask

    // offer one byte after a random gap and hold it until taken
    task send_byte(input logic [7:0] code);
        int gap;
        gap = draw_wait(fast_left > 0 ? PACE_NONE : tx_pace);
        if (fast_left > 0)
            fast_left--;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid    <= 1'b1;
        command_byte <= code;
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    task drive_byte(input logic [7:0] code, input int kind, input draw_beat_t want);
        bit         emits;
        draw_beat_t beat;
        send_byte(code);
        predict_draw(code, emits, beat);
        if (kind == ROW_BEAT)
            pending_beats.push_back(want);
        else if (kind == ROW_PREDICT && emits)
            pending_beats.push_back(beat);
        bytes_sent++;
    endtask

    task flag_mismatch(input string field, input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $error("%s: expected %h, got %h", field, want, got);
    endtask

    // result receiver with random stalls and one long hold-off
    initial
    begin
        int stall;
        int beats;
        res_ready <= 1'b0;
        rx_pace = PACE_ANY;
        beats = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                stall = draw_wait(rx_pace);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_valid);
            beats++;
            if (beats % 64 == 0)
                rx_pace = $urandom_range(PACE_NONE, PACE_SPARSE);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_ready)
            input_stalls++;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                mismatches++;
                $error("unexpected draw beat, command %0d", command);
            end
            else
            begin
                got_want = pending_beats.pop_front();
                if (command !== got_want.command)
                    flag_mismatch("command", 32'(got_want.command), 32'(command));
                if (from_x !== got_want.from_x)
                    flag_mismatch("from_x", got_want.from_x, from_x);
                if (from_y !== got_want.from_y)
                    flag_mismatch("from_y", got_want.from_y, from_y);
                if (to_x !== got_want.to_x)
                    flag_mismatch("to_x", got_want.to_x, to_x);
                if (to_y !== got_want.to_y)
                    flag_mismatch("to_y", got_want.to_y, to_y);
                if (argument !== got_want.argument)
                    flag_mismatch("argument", got_want.argument, argument);
                if (got_want.command == RES_LINE)
                    line_beats++;
                else if (got_want.command == RES_PAUSE)
                    pause_beats++;
                else
                    other_beats++;
            end
        end
    end

    // stimulus
    initial
    begin
        int          counted;
        int          directed;
        int          kind;
        int          n_prefix;
        logic [7:0]  code;
        bit          hold_used;

        cmd_valid    <= 1'b0;
        command_byte <= '0;
        pos_x        = '0;
        pos_y        = '0;
        last_x       = '0;
        last_y       = '0;
        pen_is_down  = 1'b0;
        in_prefix    = 1'b0;
        prefix_value = '0;
        held_delay   = '0;
        mismatches   = 0;
        bytes_sent   = 0;
        line_beats   = 0;
        pause_beats  = 0;
        other_beats  = 0;
        input_stalls = 0;
        tx_pace      = PACE_ANY;
        fast_left    = 0;
        hold_request = 1'b0;
        hold_used    = 1'b0;
        counted      = 0;

        // directed rows, starting from the reset state with the pen up
        add_row(CMD_CLEAR,  ROW_BEAT, make_beat(RES_CLEAR,  '0, '0, '0, '0, '0));
        add_row(CMD_KEY,    ROW_BEAT, make_beat(RES_KEY,    '0, '0, '0, '0, '0));
        add_row(CMD_PAUSE,  ROW_BEAT, make_beat(RES_PAUSE,  '0, '0, '0, '0, '0));
        add_row(CMD_COLOUR, ROW_BEAT, make_beat(RES_COLOUR, '0, '0, '0, '0, '0));
        // y move with the pen up draws nothing but moves the previous point
        add_row(make_byte(OPC_MOVE_Y, 6'h3f), ROW_QUIET, '0);
        add_row(CMD_PEN, ROW_QUIET, '0);
        add_row(make_byte(OPC_MOVE_X, 6'h3f), ROW_QUIET, '0);
        add_row(make_byte(OPC_MOVE_Y, 6'h1f), ROW_BEAT,
                make_beat(RES_LINE, 32'd0, 32'hffffffff, 32'hffffffff, 32'd30, '0));
        // most negative short operands
        add_row(make_byte(OPC_MOVE_X, 6'h20), ROW_PREDICT, '0);
        add_row(make_byte(OPC_MOVE_Y, 6'h20), ROW_PREDICT, '0);
        // negative long operand into the pause delay
        add_row(make_byte(OPC_PREFIX, 6'h20), ROW_PREDICT, '0);
        add_row(make_byte(OPC_PREFIX, 6'h3f), ROW_PREDICT, '0);
        add_row(CMD_PAUSE, ROW_PREDICT, '0);
        add_row(make_byte(OPC_PREFIX, 6'h01), ROW_QUIET, '0);
        add_row(CMD_COLOUR, ROW_BEAT, make_beat(RES_COLOUR, '0, '0, '0, '0, 32'd1));
        // long prefix chain pushes bits out past bit 31
        add_row(make_byte(OPC_PREFIX, 6'h1f), ROW_PREDICT, '0);
        add_row(make_byte(OPC_PREFIX, 6'h2a), ROW_PREDICT, '0);
        add_row(make_byte(OPC_PREFIX, 6'h15), ROW_PREDICT, '0);
        add_row(make_byte(OPC_PREFIX, 6'h3f), ROW_PREDICT, '0);
        add_row(make_byte(OPC_PREFIX, 6'h00), ROW_PREDICT, '0);
        add_row(make_byte(OPC_PREFIX, 6'h33), ROW_PREDICT, '0);
        add_row(make_byte(OPC_MOVE_Y, 6'h3f), ROW_PREDICT, '0);
        // unassigned command byte drops a pending long operand
        add_row(make_byte(OPC_PREFIX, 6'h1f), ROW_QUIET, '0);
        add_row(make_byte(OPC_CMD, 6'h3f), ROW_QUIET, '0);
        add_row(CMD_COLOUR, ROW_BEAT, make_beat(RES_COLOUR, '0, '0, '0, '0, '0));
        // zero operand pause keeps the stored delay
        add_row(CMD_PAUSE, ROW_PREDICT, '0);

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (stim_rows[i])
            drive_byte(stim_rows[i].code, stim_rows[i].kind, stim_rows[i].want);
        directed = bytes_sent;

        // random sequences: prefixed moves and commands, pen toggles, noise
        while (counted < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            n_prefix = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7)
                                                   : $urandom_range(0, 2);
            if (kind < 40 || (kind >= 52 && kind < 80))
            begin
                repeat (n_prefix)
                begin
                    drive_byte(make_byte(OPC_PREFIX, 6'($urandom)), ROW_PREDICT, '0);
                    counted++;
                end
            end
            if (kind < 40)
                code = make_byte(($urandom_range(0, 1) == 0) ? OPC_MOVE_X : OPC_MOVE_Y,
                                 6'($urandom));
            else if (kind < 52)
                code = CMD_PEN;
            else if (kind < 80)
                code = CMD_PAUSE + 8'($urandom_range(0, 3));
            else
                code = 8'($urandom_range(0, 255));
            drive_byte(code, ROW_PREDICT, '0);
            if (!(code[7:6] == OPC_CMD && code > CMD_COLOUR))
                counted++;

            if (counted % 100 < 3)
                tx_pace = $urandom_range(PACE_NONE, PACE_SPARSE);
            // long receiver hold-off while bytes keep coming back to back
            if (!hold_used && counted >= HOLD_AT_ITEM)
            begin
                hold_used    = 1'b1;
                hold_request = 1'b1;
                fast_left    = FAST_ITEMS;
            end
        end
        cmd_valid <= 1'b0;

        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d command bytes (%0d directed) and %0d draw beats:",
                 bytes_sent, directed, line_beats + pause_beats + other_beats);
        $display("  %0d lines, %0d pauses, %0d clear/key/colour, %0d input stall cycles",
                 line_beats, pause_beats, other_beats, input_stalls);
        if (mismatches == 0)
            $display("vector_draw_command_decoder_top_test passed");
        else
            $display("vector_draw_command_decoder_top_test failed");
        $finish;
    end

endmodule
